FILE: design/sbus_frame_receiver_macros.svh
// Assertion macros for the SBUS frame receiver.
// Both forms sample on i_clk and are disabled while i_rst_n is low.
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define SBUS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbus assertion failed");
`define SBUS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbus assertion failed");
`else
`define SBUS_ASSERT_IMP(lbl, ante, cons)
`define SBUS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/sbus_pkg.sv
`timescale 1ns / 1ps
package sbus_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int PAYLOAD_BYTES = 23;

    localparam int CH_W   = 4;
    localparam int RAW_W  = 11;
    localparam int NORM_W = 16;
    localparam int FLAG_W = 4;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W  = 5;
    localparam int ACC_W  = 18;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;
    localparam logic [ADDR_W-1:0] FLAG_ADDR   = ADDR_W'(PAYLOAD_BYTES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(PAYLOAD_BYTES - 1);
    localparam logic [CH_W-1:0]   LAST_CH     = CH_W'(CHANNEL_COUNT - 1);

    localparam logic [RAW_W-1:0] SYM_CENTER = 11'd992;
    localparam logic [RAW_W-1:0] ASYM_BASE  = 11'd172;

    // floor(x * 2^k / 205) with a positive offset of 205 * 2^15 folded into the bias
    localparam int U_W        = 24;
    localparam int SYM_SHIFT  = 12;
    localparam int ASYM_SHIFT = 11;
    localparam logic [U_W-1:0] SYM_BIAS  = 24'd2654208;
    localparam logic [U_W-1:0] ASYM_BIAS = 24'd6365184;
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] RECIP = 25'd20951060;
    localparam int PROD_W = U_W + RECIP_W;
    localparam int Q_LSB  = 32;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_FOOTER,
        PH_DISCARD,
        PH_FLAGS,
        PH_EMIT
    } t_phase;

    typedef struct packed {
        logic [CH_W-1:0]   index;
        logic [RAW_W-1:0]  raw;
        logic              sym;
        logic [FLAG_W-1:0] flags;
        logic              last;
    } t_chan;

endpackage

FILE: design/sbus_byte_if.sv
`timescale 1ns / 1ps
interface sbus_byte_if;
    import sbus_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/sbus_cfg_if.sv
`timescale 1ns / 1ps
interface sbus_cfg_if;
    import sbus_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CHANNEL_COUNT-1:0] symmetric_mask;

    modport source (output valid, output symmetric_mask, input ready);
    modport sink (input valid, input symmetric_mask, output ready);
endinterface

FILE: design/sbus_res_if.sv
`timescale 1ns / 1ps
interface sbus_res_if;
    import sbus_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel_index;
    logic [RAW_W-1:0]         raw_value;
    logic signed [NORM_W-1:0] normalized_value;
    logic [FLAG_W-1:0]        frame_flags;
    logic                     last_channel;

    modport source (
        output valid, output channel_index, output raw_value,
        output normalized_value, output frame_flags, output last_channel,
        input ready
    );
    modport sink (
        input valid, input channel_index, input raw_value,
        input normalized_value, input frame_flags, input last_channel,
        output ready
    );
endinterface

FILE: design/sbus_ram.sv
`timescale 1ns / 1ps
module sbus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 23
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sbus_ctrl.sv
`timescale 1ns / 1ps
module sbus_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sbus_byte_if.sink                         i_rx,
    input  logic [sbus_pkg::CHANNEL_COUNT-1:0] i_mask,
    output sbus_pkg::t_chan                   o_chan,
    output logic                              o_chan_valid,
    input  logic                              i_chan_ready,
    output logic                              o_in_footer
);
    import sbus_pkg::*;

    t_phase              r_phase, n_phase;
    logic [ADDR_W-1:0]   r_byte_count, n_byte_count;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_rd_pend, n_rd_pend;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [FLAG_W-1:0]   r_flags, n_flags;

    logic                rx_xfer;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data;

    sbus_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_BYTES)
    ) u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_byte_count),
        .i_wr_data (i_rx.rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_rx.ready = (r_phase != PH_FLAGS) && (r_phase != PH_EMIT);
    assign rx_xfer    = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_byte_count <= '0;
            r_cnt        <= '0;
            r_rd_addr    <= '0;
            r_rd_pend    <= 1'b0;
            r_ch         <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_cnt        <= n_cnt;
            r_rd_addr    <= n_rd_addr;
            r_rd_pend    <= n_rd_pend;
            r_ch         <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_flags <= n_flags;
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_rd_addr    = r_rd_addr;
        n_rd_pend    = r_rd_pend;
        n_ch         = r_ch;
        n_flags      = r_flags;
        wr_en        = 1'b0;
        rd_addr      = r_rd_addr;
        o_chan_valid = 1'b0;

        unique case (r_phase)
            PH_HUNT: begin
                if (rx_xfer && i_rx.rx_byte == HEADER_BYTE) begin
                    n_phase      = PH_PAYLOAD;
                    n_byte_count = '0;
                end
            end
            PH_PAYLOAD: begin
                if (rx_xfer) begin
                    wr_en = 1'b1;
                    if (r_byte_count == LAST_ADDR) begin
                        n_byte_count = '0;
                        n_phase      = PH_FOOTER;
                    end else begin
                        n_byte_count = r_byte_count + 1'b1;
                    end
                end
            end
            PH_FOOTER: begin
                if (rx_xfer) begin
                    if (i_rx.rx_byte == FOOTER_BYTE) begin
                        rd_addr = FLAG_ADDR;
                        n_phase = PH_FLAGS;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end
            end
            PH_DISCARD: begin
                if (rx_xfer && i_rx.rx_byte == FOOTER_BYTE) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_FLAGS: begin
                n_flags   = rd_data[FLAG_W-1:0];
                n_acc     = '0;
                n_cnt     = '0;
                n_rd_addr = '0;
                n_rd_pend = 1'b0;
                n_ch      = '0;
                n_phase   = PH_EMIT;
            end
            PH_EMIT: begin
                priority if (r_rd_pend) begin
                    // read data lands above the bits still held
                    n_acc     = r_acc | (ACC_W'(rd_data) << r_cnt);
                    n_cnt     = r_cnt + CNT_W'(BYTE_W);
                    n_rd_pend = 1'b0;
                end else if (r_cnt >= CNT_W'(RAW_W)) begin
                    o_chan_valid = 1'b1;
                    if (i_chan_ready) begin
                        n_acc = r_acc >> RAW_W;
                        n_cnt = r_cnt - CNT_W'(RAW_W);
                        n_ch  = r_ch + 1'b1;
                        if (r_ch == LAST_CH) begin
                            n_phase = PH_HUNT;
                        end
                    end
                end else begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_rd_pend = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    assign o_chan.index = r_ch;
    assign o_chan.raw   = r_acc[RAW_W-1:0];
    assign o_chan.sym   = i_mask[r_ch];
    assign o_chan.flags = r_flags;
    assign o_chan.last  = (r_ch == LAST_CH);
    assign o_in_footer  = (r_phase == PH_FOOTER);

endmodule

FILE: design/sbus_norm.sv
`timescale 1ns / 1ps
module sbus_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sbus_pkg::t_chan i_chan,
    input  logic            i_chan_valid,
    output logic            o_chan_ready,
    sbus_res_if.source      o_res
);
    import sbus_pkg::*;

    logic               en;
    logic [U_W-1:0]     u_in;
    logic [NORM_W-1:0]  q;

    logic               r_s1_valid;
    t_chan              r_s1_chan;
    logic [U_W-1:0]     r_s1_u;
    logic               r_s2_valid;
    t_chan              r_s2_chan;
    logic [PROD_W-1:0]  r_s2_prod;
    logic               r_out_valid;
    t_chan              r_out_chan;
    logic [NORM_W-1:0]  r_out_norm;

    assign en           = !r_out_valid || o_res.ready;
    assign o_chan_ready = en;

    // offset numerator, always positive
    assign u_in = i_chan.sym ? (U_W'(i_chan.raw) << SYM_SHIFT) + SYM_BIAS
                             : (U_W'(i_chan.raw) << ASYM_SHIFT) + ASYM_BIAS;

    // quotient stays below 2^16, so removing the offset is a sign-bit flip
    assign q = r_s2_prod[Q_LSB +: NORM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_chan_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_chan  <= i_chan;
            r_s1_u     <= u_in;
            r_s2_chan  <= r_s1_chan;
            r_s2_prod  <= PROD_W'(r_s1_u) * PROD_W'(RECIP);
            r_out_chan <= r_s2_chan;
            r_out_norm <= {~q[NORM_W-1], q[NORM_W-2:0]};
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.channel_index    = r_out_chan.index;
    assign o_res.raw_value        = r_out_chan.raw;
    assign o_res.normalized_value = $signed(r_out_norm);
    assign o_res.frame_flags      = r_out_chan.flags;
    assign o_res.last_channel     = r_out_chan.last;

endmodule

FILE: design/sbus_frame_receiver.sv
// channel  | dir | handshake     | payload
// i_rx     | in  | valid / ready | rx_byte
// i_cfg    | in  | valid / ready | symmetric_mask (always ready)
// o_res    | out | valid / ready | channel_index, raw_value, normalized_value,
//          |     |               | frame_flags, last_channel
// Input bytes are accepted whenever valid while framing. After a good footer, input
// stays blocked while the single read port of the payload RAM is walked (flag byte,
// then 22 payload bytes, with each channel emitted once 11 bits are held).
// Results leave through a three-stage normalize pipeline whose last stage is the output register.
// Sync reset clears framing and pipeline valids; payload RAM is not cleared.
// A stalled output freezes the pipeline and holds the channel unpacker at its next channel emit.
`timescale 1ns / 1ps
`include "sbus_frame_receiver_macros.svh"
module sbus_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbus_byte_if.sink  i_rx,
    sbus_cfg_if.sink   i_cfg,
    sbus_res_if.source o_res
);
    import sbus_pkg::*;

    logic [CHANNEL_COUNT-1:0] r_mask;
    logic [CH_W-1:0]          r_exp_idx;
    t_chan                    chan;
    logic                     chan_valid;
    logic                     chan_ready;
    logic                     in_footer;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_exp_idx <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_mask <= i_cfg.symmetric_mask;
            end
            if (o_res.valid && o_res.ready) begin
                r_exp_idx <= r_exp_idx + 1'b1;
            end
        end
    end

    sbus_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_mask       (r_mask),
        .o_chan       (chan),
        .o_chan_valid (chan_valid),
        .i_chan_ready (chan_ready),
        .o_in_footer  (in_footer)
    );

    sbus_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chan       (chan),
        .i_chan_valid (chan_valid),
        .o_chan_ready (chan_ready),
        .o_res        (o_res)
    );

    `SBUS_ASSERT_IMP(a_chan_order, o_res.valid, o_res.channel_index == r_exp_idx)
    `SBUS_ASSERT_IMP(a_sym_sign, o_res.valid && r_mask[o_res.channel_index], o_res.normalized_value[NORM_W-1] == (o_res.raw_value < SYM_CENTER))
    `SBUS_ASSERT_IMP(a_asym_sign, o_res.valid && !r_mask[o_res.channel_index], o_res.normalized_value[NORM_W-1] == (o_res.raw_value < ASYM_BASE))
    `SBUS_ASSERT_NXT(a_footer_blocks, i_rx.valid && i_rx.ready && in_footer && i_rx.rx_byte == FOOTER_BYTE, !i_rx.ready)

endmodule
